@@ rtl/lhh_pkg.sv @@
// lhh_pkg: shared types, field widths, codes and reset values for the
// layered hit-map histogrammer. No dependencies; used by every rtl module.
package lhh_pkg;

    // default sizing
    localparam int DEF_NUM_LAYERS     = 7;
    localparam int DEF_NUM_FIBERS     = 55;
    localparam int DEF_NUM_THRESHOLDS = 6;
    localparam int DEF_BIN_WIDTH      = 48;

    // request fields
    localparam int OPCODE_W = 2;
    localparam int FIBER_W  = 8;
    localparam int Z_W      = 24;
    localparam int ENERGY_W = 16;
    localparam int TSEL_W   = 4;
    localparam int LSEL_W   = 5;
    localparam int S_TDATA_W = 64;

    // result fields
    localparam int STATUS_W     = 2;
    localparam int HIT_LAYER_W  = 5;
    localparam int PASSED_W     = 5;
    localparam int BIN_VALUE_W  = 48;
    localparam int OUT_FIELDS_W = STATUS_W + HIT_LAYER_W + PASSED_W + BIN_VALUE_W;
    localparam int M_TDATA_W    = 64;

    // threshold products: 15 * 65535 fits in 20 bits
    localparam int THR_W = 20;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNT_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_Z_START    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_THICKNESS  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP       = 2'd3;

    localparam logic signed [Z_W-1:0] RST_Z_START   = 24'sd226000;
    localparam logic [ENERGY_W-1:0]   RST_THICKNESS = 16'd2000;
    localparam logic [ENERGY_W-1:0]   RST_STEP      = 16'd100;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_HIT      = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ     = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ_CLR = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_NO_LAYER,
        ST_BAD_FIBER,
        ST_BAD_ADDR
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_FIND,
        S_MOD,
        S_DONE
    } t_state;

    // per-bank command: read, saturating add, write zero
    typedef struct packed {
        logic rd;
        logic add;
        logic clr;
    } t_bank_op;

    // layer search response
    typedef struct packed {
        logic                   done;
        logic                   found;
        logic [HIT_LAYER_W-1:0] layer;
    } t_find_rsp;

    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

@@ rtl/lhh_layer_finder.sv @@
// lhh_layer_finder: walks the layer slabs one per cycle to find a hit's layer.
// Depends on lhh_pkg.
module lhh_layer_finder
    import lhh_pkg::*;
#(
    parameter int NUM_LAYERS = DEF_NUM_LAYERS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [Z_W-1:0]      i_z,
    input  logic signed [Z_W-1:0]      i_z_start,
    input  logic [ENERGY_W-1:0]        i_thickness,
    output t_find_rsp                  o_rsp
);

    localparam int LW = addr_bits(NUM_LAYERS);
    localparam int DW = Z_W + 1;

    logic          r_busy;
    logic [DW-1:0] r_d;
    logic [DW-1:0] r_bound;
    logic [LW-1:0] r_layer;

    logic neg;
    logic in_slab;
    logic last;
    logic resolved;

    assign neg      = r_d[DW-1];
    // upper edge of slab r_layer, boundary goes to the lower layer
    assign in_slab  = !neg && (r_d <= r_bound);
    assign last     = (r_layer == LW'(NUM_LAYERS - 1));
    assign resolved = r_busy && (neg || in_slab || last);

    assign o_rsp.done  = resolved;
    assign o_rsp.found = r_busy && in_slab;
    assign o_rsp.layer = HIT_LAYER_W'(r_layer);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (resolved) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d     <= {i_z[Z_W-1], i_z} - {i_z_start[Z_W-1], i_z_start};
            r_bound <= DW'(i_thickness);
            r_layer <= '0;
        end else if (r_busy && !resolved) begin
            r_bound <= r_bound + DW'(i_thickness);
            r_layer <= r_layer + 1'b1;
        end
    end

endmodule

@@ rtl/lhh_bank.sv @@
// lhh_bank: one threshold's bin memory with read-modify-write saturating add
// and clear. Depends on lhh_pkg.
module lhh_bank
    import lhh_pkg::*;
#(
    parameter int DEPTH  = DEF_NUM_LAYERS * DEF_NUM_FIBERS,
    parameter int BIN_W  = DEF_BIN_WIDTH,
    parameter int ADDR_W = addr_bits(DEPTH)
) (
    input  logic                 i_clk,
    input  t_bank_op             i_op,
    input  logic [ADDR_W-1:0]    i_addr,
    input  logic [ENERGY_W-1:0]  i_add_val,
    output logic [BIN_W-1:0]     o_rd_data
);

    logic [BIN_W-1:0] mem [DEPTH];
    logic [BIN_W-1:0] r_rd_data;
    logic [BIN_W:0]   sum;
    logic [BIN_W-1:0] n_wr_data;

    // add uses the word read in the previous cycle at the same address
    assign sum       = {1'b0, r_rd_data} + (BIN_W + 1)'(i_add_val);
    assign n_wr_data = i_op.clr ? '0 : (sum[BIN_W] ? '1 : sum[BIN_W-1:0]);
    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_op.rd) begin
            r_rd_data <= mem[i_addr];
        end
        if (i_op.add || i_op.clr) begin
            mem[i_addr] <= n_wr_data;
        end
    end

endmodule

@@ rtl/layered_hitmap_histogrammer.sv @@
// layered_hitmap_histogrammer: a bad read address or unused opcode goes straight
// to the result, a read through one bank read-modify-write, a hit through the
// layer search (one slab per cycle), then one read-modify-write of the passed
// banks; the output can stall. One request in flight, the next taken the cycle
// after its result is loaded. One bank per threshold. After reset the banks are
// zeroed over all NUM_LAYERS*NUM_FIBERS addresses (385 by default), tready low.
module layered_hitmap_histogrammer
    import lhh_pkg::*;
#(
    parameter int NUM_LAYERS     = DEF_NUM_LAYERS,
    parameter int NUM_FIBERS     = DEF_NUM_FIBERS,
    parameter int NUM_THRESHOLDS = DEF_NUM_THRESHOLDS,
    parameter int BIN_WIDTH      = DEF_BIN_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    // opcode[1:0], fiber[9:2], z_um[33:10], energy_kev[49:34],
    // threshold_index[53:50], layer_index[58:54], zero fill above
    input  logic [S_TDATA_W-1:0]    i_s_tdata,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    // status[1:0], hit_layer[6:2], thresholds_passed[11:7],
    // bin_value[59:12], zero fill above
    output logic [M_TDATA_W-1:0]    o_m_tdata
);

    localparam int DEPTH  = NUM_LAYERS * NUM_FIBERS;
    localparam int ADDR_W = addr_bits(DEPTH);
    localparam int TW     = addr_bits(NUM_THRESHOLDS);

    // configuration
    logic                    r_count_mode;
    logic signed [Z_W-1:0]   r_z_start;
    logic [ENERGY_W-1:0]     r_thickness;
    logic [ENERGY_W-1:0]     r_step;

    // control
    t_state                  r_state, n_state;
    logic [ADDR_W-1:0]       r_clr_addr;
    logic [ADDR_W-1:0]       r_addr;
    logic                    r_out_valid;
    logic [M_TDATA_W-1:0]    r_out_data;

    // latched request
    logic [OPCODE_W-1:0]     r_op;
    logic [FIBER_W-1:0]      r_fiber;
    logic signed [Z_W-1:0]   r_z;
    logic [ENERGY_W-1:0]     r_energy;
    logic [TSEL_W-1:0]       r_tsel;
    logic [LSEL_W-1:0]       r_lsel;

    // result
    t_status                 r_status, n_status;
    logic [HIT_LAYER_W-1:0]  r_layer, n_layer;
    logic [PASSED_W-1:0]     r_passed, n_passed;
    logic [BIN_WIDTH-1:0]    r_value, n_value;

    logic                    accept;
    logic                    issue;
    logic                    find_start;
    logic                    load_out;
    logic                    bad_read;
    logic                    bad_fiber;
    logic [HIT_LAYER_W-1:0]  sel_layer;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       bank_addr;
    logic [ENERGY_W-1:0]     add_val;
    logic [NUM_THRESHOLDS-1:0] pass;
    logic [BIN_VALUE_W-1:0]  out_value;
    t_find_rsp               find_rsp;
    t_bank_op                bank_op [NUM_THRESHOLDS];
    logic [BIN_WIDTH-1:0]    bank_rd [NUM_THRESHOLDS];

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign bad_fiber = ({1'b0, r_fiber} >= (FIBER_W + 1)'(NUM_FIBERS));
    assign bad_read  = ({1'b0, r_tsel} >= (TSEL_W + 1)'(NUM_THRESHOLDS))
                    || ({1'b0, r_lsel} >= (LSEL_W + 1)'(NUM_LAYERS))
                    || bad_fiber;

    assign sel_layer = (r_state == S_FIND) ? find_rsp.layer : r_lsel;
    assign rd_addr   = ADDR_W'(sel_layer) * ADDR_W'(NUM_FIBERS) + ADDR_W'(r_fiber);
    assign bank_addr = issue ? rd_addr : ((r_state == S_CLEAR) ? r_clr_addr : r_addr);
    assign add_val   = r_count_mode ? r_energy : ENERGY_W'(1);

    lhh_layer_finder #(
        .NUM_LAYERS (NUM_LAYERS)
    ) u_finder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (find_start),
        .i_z         (r_z),
        .i_z_start   (r_z_start),
        .i_thickness (r_thickness),
        .o_rsp       (find_rsp)
    );

    for (genvar t = 0; t < NUM_THRESHOLDS; t++) begin : g_bank
        assign pass[t] = (THR_W'(r_energy) > THR_W'(t) * THR_W'(r_step));

        lhh_bank #(
            .DEPTH  (DEPTH),
            .BIN_W  (BIN_WIDTH),
            .ADDR_W (ADDR_W)
        ) u_bank (
            .i_clk     (i_clk),
            .i_op      (bank_op[t]),
            .i_addr    (bank_addr),
            .i_add_val (add_val),
            .o_rd_data (bank_rd[t])
        );
    end

    if (BIN_WIDTH >= BIN_VALUE_W) begin : g_val_trunc
        assign out_value = r_value[BIN_VALUE_W-1:0];
    end else begin : g_val_ext
        assign out_value = {{(BIN_VALUE_W - BIN_WIDTH){1'b0}}, r_value};
    end

    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        n_layer    = r_layer;
        n_passed   = r_passed;
        n_value    = r_value;
        issue      = 1'b0;
        find_start = 1'b0;
        load_out   = 1'b0;
        o_s_tready = 1'b0;
        for (int t = 0; t < NUM_THRESHOLDS; t++) begin
            bank_op[t] = '0;
        end
        case (r_state)
            S_CLEAR: begin
                for (int t = 0; t < NUM_THRESHOLDS; t++) begin
                    bank_op[t].clr = 1'b1;
                end
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_status = ST_OK;
                n_layer  = '0;
                n_passed = '0;
                n_value  = '0;
                case (r_op)
                    OP_HIT: begin
                        find_start = 1'b1;
                        n_state    = S_FIND;
                    end
                    OP_READ, OP_READ_CLR: begin
                        if (bad_read) begin
                            n_status = ST_BAD_ADDR;
                            n_state  = S_DONE;
                        end else begin
                            issue = 1'b1;
                            for (int t = 0; t < NUM_THRESHOLDS; t++) begin
                                bank_op[t].rd = 1'b1;
                            end
                            n_state = S_MOD;
                        end
                    end
                    default: begin
                        n_status = ST_BAD_ADDR;
                        n_state  = S_DONE;
                    end
                endcase
            end
            S_FIND: begin
                if (find_rsp.done) begin
                    if (!find_rsp.found) begin
                        n_status = ST_NO_LAYER;
                        n_state  = S_DONE;
                    end else if (bad_fiber) begin
                        n_status = ST_BAD_FIBER;
                        n_state  = S_DONE;
                    end else begin
                        issue   = 1'b1;
                        n_layer = find_rsp.layer;
                        for (int t = 0; t < NUM_THRESHOLDS; t++) begin
                            bank_op[t].rd = 1'b1;
                        end
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                // read data from the issue cycle is valid here; write back now
                if (r_op == OP_HIT) begin
                    for (int t = 0; t < NUM_THRESHOLDS; t++) begin
                        bank_op[t].add = pass[t];
                    end
                    n_passed = PASSED_W'($countones(pass));
                end else begin
                    n_value = bank_rd[r_tsel[TW-1:0]];
                    for (int t = 0; t < NUM_THRESHOLDS; t++) begin
                        bank_op[t].clr = (r_op == OP_READ_CLR) && (r_tsel == TSEL_W'(t));
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
            r_count_mode <= 1'b0;
            r_z_start    <= RST_Z_START;
            r_thickness  <= RST_THICKNESS;
            r_step       <= RST_STEP;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_COUNT_MODE: r_count_mode <= i_cfg_wdata[0];
                    CFG_Z_START:    r_z_start    <= i_cfg_wdata[Z_W-1:0];
                    CFG_THICKNESS:  r_thickness  <= i_cfg_wdata[ENERGY_W-1:0];
                    CFG_STEP:       r_step       <= i_cfg_wdata[ENERGY_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_s_tdata[1:0];
            r_fiber  <= i_s_tdata[9:2];
            r_z      <= i_s_tdata[33:10];
            r_energy <= i_s_tdata[49:34];
            r_tsel   <= i_s_tdata[53:50];
            r_lsel   <= i_s_tdata[58:54];
        end
        if (issue) begin
            r_addr <= rd_addr;
        end
        r_status <= n_status;
        r_layer  <= n_layer;
        r_passed <= n_passed;
        r_value  <= n_value;
        if (load_out) begin
            r_out_data <= {(M_TDATA_W - OUT_FIELDS_W)'(0), out_value, r_passed, r_layer,
                           r_status};
        end
    end

`ifndef SYNTHESIS
    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_tready)
        else $error("request taken during clearing pass");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DECODE))
        else $error("accepted request not decoded");

    a_passed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[11:7] <= PASSED_W'(NUM_THRESHOLDS)))
        else $error("thresholds_passed above threshold count");

    a_fail_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[1:0] != ST_OK)) |-> (o_m_tdata[59:12] == '0))
        else $error("failed request carries a bin value");
`endif

endmodule
